// ----- rtl/core/wmm_pkg.sv -----
// Shared types, widths and codes for the windowed min/max/mean unit.
package wmm_pkg;

  localparam int TsW     = 48;
  localparam int LoadW   = 24;
  localparam int MemW    = 48;
  localparam int InstW   = 16;
  localparam int TickW   = 12;
  localparam int LoadSumW = 36;
  localparam int MemSumW  = 60;
  localparam int InstSumW = 28;
  localparam int MeanFracW = 8;

  localparam int InDataW  = 136;
  localparam int OutDataW = 320;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  // One lane per mean, all sized for the widest dividend.
  localparam int NumLanes = 3;
  localparam int DivW     = MemSumW;
  localparam int StepW    = $clog2(DivW);

  localparam int LaneLoad = 0;
  localparam int LaneMem  = 1;
  localparam int LaneInst = 2;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [TickW-1:0] WindowTicksReset = TickW'(60);
  localparam logic [0:0] RegWindowTicks = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } wmm_state_t;

  // Closed window as handed from the accumulator to the divider side.
  typedef struct packed {
    logic [TsW-1:0]      start;
    logic [LoadW-1:0]    load_lo;
    logic [LoadW-1:0]    load_hi;
    logic [LoadSumW-1:0] load_sum;
    logic [MemW-1:0]     mem_lo;
    logic [MemW-1:0]     mem_hi;
    logic [MemSumW-1:0]  mem_sum;
    logic [InstW-1:0]    inst_lo;
    logic [InstW-1:0]    inst_hi;
    logic [InstSumW-1:0] inst_sum;
    logic [TickW-1:0]    count;
  } wmm_snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wmm_qstat_t;

endpackage

// ----- rtl/core/wmm_front.sv -----
// Tick accumulator: running min, max and sum per window, non-empty windows pushed out.
module wmm_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [wmm_pkg::InDataW-1:0]     in_tdata,
  input  logic [wmm_pkg::TickW-1:0]       window_ticks,
  input  wmm_pkg::wmm_qstat_t             q_stat,
  output logic                            q_push,
  output wmm_pkg::wmm_snap_t              q_snap
);

  logic [wmm_pkg::TsW-1:0]      ts;
  logic [wmm_pkg::LoadW-1:0]    load;
  logic [wmm_pkg::MemW-1:0]     mem;
  logic [wmm_pkg::InstW-1:0]    inst;

  logic [wmm_pkg::TickW-1:0]    tick_r, tick_nxt;
  logic [wmm_pkg::TsW-1:0]      wstart_r, wstart_nxt;
  logic [wmm_pkg::TsW-1:0]      fst_r, fst_nxt;
  logic [wmm_pkg::TickW-1:0]    cnt_r, cnt_nxt;
  logic [wmm_pkg::LoadW-1:0]    load_lo_r, load_lo_nxt, load_hi_r, load_hi_nxt;
  logic [wmm_pkg::LoadSumW-1:0] load_sum_r, load_sum_nxt;
  logic [wmm_pkg::MemW-1:0]     mem_lo_r, mem_lo_nxt, mem_hi_r, mem_hi_nxt;
  logic [wmm_pkg::MemSumW-1:0]  mem_sum_r, mem_sum_nxt;
  logic [wmm_pkg::InstW-1:0]    inst_lo_r, inst_lo_nxt, inst_hi_r, inst_hi_nxt;
  logic [wmm_pkg::InstSumW-1:0] inst_sum_r, inst_sum_nxt;

  logic accept;
  logic sample;
  logic close;

  assign ts   = in_tdata[47:0];
  assign load = in_tdata[71:48];
  assign mem  = in_tdata[119:72];
  assign inst = in_tdata[135:120];

  assign in_tready = ~q_stat.full;
  assign accept    = in_tvalid & in_tready;
  assign sample    = (inst != '0);

  always_comb begin
    wstart_nxt   = (tick_r == '0) ? ts : wstart_r;
    fst_nxt      = (sample && cnt_r == '0) ? ts : fst_r;
    cnt_nxt      = sample ? cnt_r + 1'b1 : cnt_r;
    load_lo_nxt  = (sample && load < load_lo_r) ? load : load_lo_r;
    load_hi_nxt  = (sample && load > load_hi_r) ? load : load_hi_r;
    load_sum_nxt = sample ? load_sum_r + wmm_pkg::LoadSumW'(load) : load_sum_r;
    mem_lo_nxt   = (sample && mem < mem_lo_r) ? mem : mem_lo_r;
    mem_hi_nxt   = (sample && mem > mem_hi_r) ? mem : mem_hi_r;
    mem_sum_nxt  = sample ? mem_sum_r + wmm_pkg::MemSumW'(mem) : mem_sum_r;
    inst_lo_nxt  = (sample && inst < inst_lo_r) ? inst : inst_lo_r;
    inst_hi_nxt  = (sample && inst > inst_hi_r) ? inst : inst_hi_r;
    inst_sum_nxt = sample ? inst_sum_r + wmm_pkg::InstSumW'(inst) : inst_sum_r;
    tick_nxt     = tick_r + 1'b1;
  end

  // A zero window length closes on every tick, as the compare already gives.
  assign close  = (tick_nxt >= window_ticks);
  assign q_push = accept & close & (cnt_nxt != '0);

  always_comb begin
    q_snap.start    = (wstart_nxt != '0) ? wstart_nxt : fst_nxt;
    q_snap.load_lo  = load_lo_nxt;
    q_snap.load_hi  = load_hi_nxt;
    q_snap.load_sum = load_sum_nxt;
    q_snap.mem_lo   = mem_lo_nxt;
    q_snap.mem_hi   = mem_hi_nxt;
    q_snap.mem_sum  = mem_sum_nxt;
    q_snap.inst_lo  = inst_lo_nxt;
    q_snap.inst_hi  = inst_hi_nxt;
    q_snap.inst_sum = inst_sum_nxt;
    q_snap.count    = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && close)) begin
      tick_r     <= '0;
      wstart_r   <= '0;
      fst_r      <= '0;
      cnt_r      <= '0;
      load_lo_r  <= '1;
      load_hi_r  <= '0;
      load_sum_r <= '0;
      mem_lo_r   <= '1;
      mem_hi_r   <= '0;
      mem_sum_r  <= '0;
      inst_lo_r  <= '1;
      inst_hi_r  <= '0;
      inst_sum_r <= '0;
    end else if (accept) begin
      tick_r     <= tick_nxt;
      wstart_r   <= wstart_nxt;
      fst_r      <= fst_nxt;
      cnt_r      <= cnt_nxt;
      load_lo_r  <= load_lo_nxt;
      load_hi_r  <= load_hi_nxt;
      load_sum_r <= load_sum_nxt;
      mem_lo_r   <= mem_lo_nxt;
      mem_hi_r   <= mem_hi_nxt;
      mem_sum_r  <= mem_sum_nxt;
      inst_lo_r  <= inst_lo_nxt;
      inst_hi_r  <= inst_hi_nxt;
      inst_sum_r <= inst_sum_nxt;
    end
  end

endmodule

// ----- rtl/core/wmm_queue.sv -----
// Two-entry queue of closed windows between the accumulator and the divider.
module wmm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  wmm_pkg::wmm_snap_t   wr_data,
  input  logic                 pop,
  output wmm_pkg::wmm_snap_t   rd_data,
  output wmm_pkg::wmm_qstat_t  stat
);

  wmm_pkg::wmm_snap_t           mem_r [wmm_pkg::QDepth];
  logic [wmm_pkg::QPtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [wmm_pkg::QPtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [wmm_pkg::QCntW-1:0]    cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == wmm_pkg::QCntW'(wmm_pkg::QDepth));
  assign stat.empty = (cnt_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == wmm_pkg::QPtrW'(wmm_pkg::QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == wmm_pkg::QPtrW'(wmm_pkg::QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full)) else $error("window pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty)) else $error("window popped from an empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= wmm_pkg::QCntW'(wmm_pkg::QDepth)) else $error("queue fill count overrun");
`endif

endmodule

// ----- rtl/core/wmm_back.sv -----
// Divider side: three restoring dividers in lockstep, then the record register.
module wmm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wmm_pkg::wmm_qstat_t           q_stat,
  input  wmm_pkg::wmm_snap_t            q_data,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [wmm_pkg::OutDataW-1:0]  out_tdata
);

  wmm_pkg::wmm_state_t          state_r, state_nxt;
  wmm_pkg::wmm_snap_t           snap_r;
  logic [wmm_pkg::StepW-1:0]    step_r;
  logic [wmm_pkg::DivW-1:0]     dvd_r [wmm_pkg::NumLanes];
  logic [wmm_pkg::TickW-1:0]    rem_r [wmm_pkg::NumLanes];
  logic [wmm_pkg::DivW-1:0]     dvd_nxt [wmm_pkg::NumLanes];
  logic [wmm_pkg::TickW-1:0]    rem_nxt [wmm_pkg::NumLanes];
  logic [wmm_pkg::TickW:0]      shifted [wmm_pkg::NumLanes];
  logic [wmm_pkg::NumLanes-1:0] fits;
  logic                         last_step;

  assign last_step = (step_r == wmm_pkg::StepW'(wmm_pkg::DivW - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wmm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      wmm_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          state_nxt = wmm_pkg::ST_DIV;
        end
      end
      wmm_pkg::ST_DIV: begin
        if (last_step) begin
          state_nxt = wmm_pkg::ST_OUT;
        end
      end
      wmm_pkg::ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = wmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wmm_pkg::ST_IDLE;
      end
    endcase
  end

  // One quotient bit per lane per cycle; the dividend register fills with the quotient.
  always_comb begin
    for (int i = 0; i < wmm_pkg::NumLanes; i++) begin
      shifted[i] = {rem_r[i], dvd_r[i][wmm_pkg::DivW-1]};
      fits[i]    = (shifted[i] >= {1'b0, snap_r.count});
      rem_nxt[i] = fits[i] ? wmm_pkg::TickW'(shifted[i] - {1'b0, snap_r.count})
                           : shifted[i][wmm_pkg::TickW-1:0];
      dvd_nxt[i] = {dvd_r[i][wmm_pkg::DivW-2:0], fits[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      snap_r <= q_data;
      step_r <= '0;
      for (int i = 0; i < wmm_pkg::NumLanes; i++) begin
        rem_r[i] <= '0;
      end
      dvd_r[wmm_pkg::LaneLoad] <= wmm_pkg::DivW'(q_data.load_sum);
      dvd_r[wmm_pkg::LaneMem]  <= q_data.mem_sum;
      dvd_r[wmm_pkg::LaneInst] <= wmm_pkg::DivW'({q_data.inst_sum,
                                                  {wmm_pkg::MeanFracW{1'b0}}});
    end else if (state_r == wmm_pkg::ST_DIV) begin
      step_r <= step_r + 1'b1;
      for (int i = 0; i < wmm_pkg::NumLanes; i++) begin
        rem_r[i] <= rem_nxt[i];
        dvd_r[i] <= dvd_nxt[i];
      end
    end
  end

  assign out_tdata = {
    dvd_r[wmm_pkg::LaneInst][wmm_pkg::LoadW-1:0],
    snap_r.inst_hi,
    snap_r.inst_lo,
    dvd_r[wmm_pkg::LaneMem][wmm_pkg::MemW-1:0],
    snap_r.mem_hi,
    snap_r.mem_lo,
    dvd_r[wmm_pkg::LaneLoad][wmm_pkg::LoadW-1:0],
    snap_r.load_hi,
    snap_r.load_lo,
    snap_r.start
  };

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wmm_pkg::ST_DIV) |-> (snap_r.count != '0))
    else $error("divider started on a window without samples");
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wmm_pkg::ST_DIV && last_step) |=> out_tvalid)
    else $error("record not presented after the last divide step");
  a_out_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == wmm_pkg::ST_DIV))
    else $error("record presented without a finished division");
`endif

endmodule

// ----- rtl/core/windowed_min_max_mean_unit.sv -----
// Top level: configuration register, accumulator, window queue and divider side.
//
// Ticks arrive on the in_ stream, one transaction per tick; a tick with a zero
// instance count is counted but adds no sample. After window_ticks ticks the
// window closes and, if it held any sample, one summary record leaves on the
// out_ stream; empty windows give nothing.
// The accumulator takes one tick per cycle while the queue has room. A closed
// window waits in a two-entry queue; the divider side takes it, runs three
// restoring dividers in lockstep (one quotient bit per cycle, one for each bit
// of the 60-bit memory sum), then holds the record in its output register
// until taken. The divider side takes the next window only once that record
// is taken. When the receiver stalls, the record holds and the accumulator keeps
// taking ticks until two more closed windows are queued; then in_tready drops.
// window_ticks sits at byte address 0 of the cfg_ port (reset 60); write it
// only while the block is idle. Synchronous reset clears the window and the
// queue, returns the divider to idle and restores window_ticks.
module windowed_min_max_mean_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // timestamp_ms, cpu_load, ram_bytes, instance_count
  input  logic [wmm_pkg::InDataW-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // start_time_ms, load_min, load_max, load_mean, mem_min, mem_max, mem_mean,
  // inst_min, inst_max, inst_mean
  output logic [wmm_pkg::OutDataW-1:0]  out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [wmm_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [wmm_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [wmm_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  logic [wmm_pkg::TickW-1:0] window_ticks_r;
  logic                      reg_hit;
  logic                      q_push;
  logic                      q_pop;
  wmm_pkg::wmm_snap_t        q_wr;
  wmm_pkg::wmm_snap_t        q_rd;
  wmm_pkg::wmm_qstat_t       q_stat;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[wmm_pkg::CfgAddrW-1] == wmm_pkg::RegWindowTicks);
  assign cfg_prdata = reg_hit ? wmm_pkg::CfgDataW'(window_ticks_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ticks_r <= wmm_pkg::WindowTicksReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      window_ticks_r <= cfg_pwdata[wmm_pkg::TickW-1:0];
    end
  end

  wmm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .window_ticks (window_ticks_r),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_snap       (q_wr)
  );

  wmm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .stat    (q_stat)
  );

  wmm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_data     (q_rd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- dv/windowed_min_max_mean_unit_test.sv -----
// Self-checking stream testbench for the windowed min/max/mean unit.
module windowed_min_max_mean_unit_test;
  import wmm_pkg::*;

  localparam int ClockHalf   = 5;
  localparam int ResetCycles = 9;
  localparam int DrainCycles = 80;
  localparam int LongHold    = 600;
  localparam int CycleLimit  = 1000000;
  localparam int PhaseTicks  = 65;

  localparam logic [CfgAddrW-1:0] AddrWindowTicks = CfgAddrW'(4 * RegWindowTicks);
  localparam logic [CfgAddrW-1:0] AddrUnmapped    = CfgAddrW'(4 * (RegWindowTicks + 1));

  // Fields listed highest first, so the last field lands in the lowest bits.
  typedef struct packed {
    logic [InstW-1:0] instance_count;
    logic [MemW-1:0]  ram_bytes;
    logic [LoadW-1:0] cpu_load;
    logic [TsW-1:0]   timestamp_ms;
  } tick_t;

  typedef struct packed {
    logic [23:0]      inst_mean;
    logic [InstW-1:0] inst_max;
    logic [InstW-1:0] inst_min;
    logic [MemW-1:0]  mem_mean;
    logic [MemW-1:0]  mem_max;
    logic [MemW-1:0]  mem_min;
    logic [LoadW-1:0] load_mean;
    logic [LoadW-1:0] load_max;
    logic [LoadW-1:0] load_min;
    logic [TsW-1:0]   start_time_ms;
  } summary_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  // timestamp_ms, cpu_load, ram_bytes, instance_count
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // start_time_ms, load_min, load_max, load_mean, mem_min, mem_max, mem_mean,
  // inst_min, inst_max, inst_mean
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr = '0;
  logic [CfgDataW-1:0] cfg_pwdata = '0;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  windowed_min_max_mean_unit dut (.*);

  always #ClockHalf clk = ~clk;

  // Window accumulator mirror
  logic [TickW-1:0]    window_len;
  logic [TickW-1:0]    win_ticks;
  logic [TsW-1:0]      win_start;
  logic [TsW-1:0]      win_first;
  logic [TickW-1:0]    win_samples;
  logic [LoadW-1:0]    load_lo, load_hi;
  logic [LoadSumW-1:0] load_sum;
  logic [MemW-1:0]     mem_lo, mem_hi;
  logic [MemSumW-1:0]  mem_sum;
  logic [InstW-1:0]    inst_lo, inst_hi;
  logic [InstSumW-1:0] inst_sum;

  tick_t    tick_queue[$];
  summary_t pending_summaries[$];

  logic in_fire = 1'b0;
  int   gap_left, burst_left;
  int   hold_requests, hold_served, hold_left, style_left, rx_style;
  int   fault_count, ticks_taken, summaries_seen, empty_windows, length_writes;
  longint cycle_count;

  function automatic void clear_window();
    win_ticks   = '0;
    win_start   = '0;
    win_first   = '0;
    win_samples = '0;
    load_lo = '1; load_hi = '0; load_sum = '0;
    mem_lo  = '1; mem_hi  = '0; mem_sum  = '0;
    inst_lo = '1; inst_hi = '0; inst_sum = '0;
  endfunction

  function automatic void accumulate_tick(tick_t tk);
    summary_t s;
    logic [InstSumW+MeanFracW-1:0] inst_scaled;
    if (win_ticks == 0) win_start = tk.timestamp_ms;
    if (tk.instance_count != 0) begin
      if (win_samples == 0) win_first = tk.timestamp_ms;
      win_samples = win_samples + 1'b1;
      if (tk.cpu_load < load_lo) load_lo = tk.cpu_load;
      if (tk.cpu_load > load_hi) load_hi = tk.cpu_load;
      load_sum = load_sum + tk.cpu_load;
      if (tk.ram_bytes < mem_lo) mem_lo = tk.ram_bytes;
      if (tk.ram_bytes > mem_hi) mem_hi = tk.ram_bytes;
      mem_sum = mem_sum + tk.ram_bytes;
      if (tk.instance_count < inst_lo) inst_lo = tk.instance_count;
      if (tk.instance_count > inst_hi) inst_hi = tk.instance_count;
      inst_sum = inst_sum + tk.instance_count;
    end
    win_ticks = win_ticks + 1'b1;
    if (win_ticks >= window_len) begin
      if (win_samples != 0) begin
        inst_scaled     = {inst_sum, {MeanFracW{1'b0}}};
        s.start_time_ms = (win_start != 0) ? win_start : win_first;
        s.load_min      = load_lo;
        s.load_max      = load_hi;
        s.load_mean     = LoadW'(load_sum / win_samples);
        s.mem_min       = mem_lo;
        s.mem_max       = mem_hi;
        s.mem_mean      = MemW'(mem_sum / win_samples);
        s.inst_min      = inst_lo;
        s.inst_max      = inst_hi;
        s.inst_mean     = 24'(inst_scaled / win_samples);
        pending_summaries.insert(pending_summaries.size(), s);
      end else begin
        empty_windows++;
      end
      clear_window();
    end
  endfunction

  function automatic void queue_tick(tick_t tk);
    tick_queue.insert(tick_queue.size(), tk);
  endfunction

  function automatic logic [63:0] rand_bits(int w);
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = 64'($urandom_range(0, 255));
      default: v = {$urandom, $urandom};
    endcase
    return v & ((64'd1 << w) - 1);
  endfunction

  function automatic tick_t mk_tick(logic [TsW-1:0] ts, logic [LoadW-1:0] load,
                                     logic [MemW-1:0] mem, logic [InstW-1:0] inst);
    tick_t tk;
    tk.timestamp_ms   = ts;
    tk.cpu_load       = load;
    tk.ram_bytes      = mem;
    tk.instance_count = inst;
    return tk;
  endfunction

  function automatic tick_t rand_tick(int sample_pct);
    logic [InstW-1:0] inst;
    inst = '0;
    if ($urandom_range(0, 99) < sample_pct) begin
      inst = InstW'(rand_bits(InstW));
      if (inst == 0) inst = InstW'(1);
    end
    return mk_tick(TsW'(rand_bits(TsW)), LoadW'(rand_bits(LoadW)), MemW'(rand_bits(MemW)), inst);
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endtask

  task automatic cfg_write(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == AddrWindowTicks) begin
      window_len = data[TickW-1:0];
      length_writes++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Hold until every tick is taken and every summary is back, then let the
  // block drain.
  task automatic settle();
    while (tick_queue.size() != 0 || in_tvalid || pending_summaries.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Driver: bursts of random length separated by random gaps
  always @(negedge clk) begin
    tick_t tk;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (tick_queue.size() != 0) begin
        tk = tick_queue.pop_front();
        in_tdata  <= tk;
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 32);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall styles that change every so often, plus requested long holds
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LongHold;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        style_left = $urandom_range(10, 150);
        rx_style   = $urandom_range(0, 3);
      end else begin
        style_left--;
      end
      case (rx_style)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= style_left[1];
      endcase
    end
  end

  // Monitor: predict on every accepted tick, check every accepted summary
  always @(posedge clk) begin
    summary_t got, want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        accumulate_tick(tick_t'(in_tdata));
        ticks_taken++;
      end
      if (out_tvalid && out_tready) begin
        got = summary_t'(out_tdata);
        summaries_seen++;
        if (pending_summaries.size() == 0) begin
          $error("summary transaction with none expected: %0h", out_tdata);
          fault_count++;
        end else begin
          want = pending_summaries.pop_front();
          check_field("start_time_ms", 64'(want.start_time_ms), 64'(got.start_time_ms));
          check_field("load_min", 64'(want.load_min), 64'(got.load_min));
          check_field("load_max", 64'(want.load_max), 64'(got.load_max));
          check_field("load_mean", 64'(want.load_mean), 64'(got.load_mean));
          check_field("mem_min", 64'(want.mem_min), 64'(got.mem_min));
          check_field("mem_max", 64'(want.mem_max), 64'(got.mem_max));
          check_field("mem_mean", 64'(want.mem_mean), 64'(got.mem_mean));
          check_field("inst_min", 64'(want.inst_min), 64'(got.inst_min));
          check_field("inst_max", 64'(want.inst_max), 64'(got.inst_max));
          check_field("inst_mean", 64'(want.inst_mean), 64'(got.inst_mean));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("windowed_min_max_mean_unit_test: errors");
      $finish;
    end
  end

  initial begin
    int lengths[8];
    int pct;
    window_len = WindowTicksReset;
    clear_window();
    lengths = '{60, 1, 2, 5, 13, 0, 62, 100};
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single-tick windows: all-ones sample, zero start with zero fields, empty window
    cfg_write(AddrWindowTicks, 1);
    queue_tick(mk_tick('1, '1, '1, '1));
    queue_tick(mk_tick('0, '0, '0, InstW'(1)));
    queue_tick(mk_tick(48'h1234, 24'h55, 48'h99, '0));
    settle();

    // Zero length with upper bits set acts as one tick per window
    cfg_write(AddrWindowTicks, 32'hFFFF_F000);
    queue_tick(mk_tick(48'hAAAA_AAAA_AAAA, 24'h555555, 48'h5555_5555_5555, 16'hAAAA));
    queue_tick(mk_tick(48'h5555_5555_5555, 24'hAAAAAA, 48'hAAAA_AAAA_AAAA, 16'h5555));
    settle();

    // Three ticks: zero start falls back to first sample time, then an empty window
    cfg_write(AddrWindowTicks, 32'hABCD_E003);
    queue_tick(mk_tick('0, 24'h100, 48'h10, '0));
    queue_tick(mk_tick(48'd1234, '1, 48'h1, 16'h1));
    queue_tick(mk_tick(48'd2000, '0, '1, '1));
    repeat (3) queue_tick(rand_tick(0));
    settle();

    // Longest window, then shorten it mid-window so it closes on the next tick
    cfg_write(AddrWindowTicks, 32'hFFFF_FFFF);
    repeat (6) queue_tick(rand_tick(100));
    settle();
    cfg_write(AddrUnmapped, 2);
    cfg_write(AddrWindowTicks, 4);
    queue_tick(rand_tick(100));
    settle();

    // Random phases over several window lengths and sample densities
    foreach (lengths[i]) begin
      cfg_write(AddrWindowTicks, lengths[i]);
      case ($urandom_range(0, 2))
        0: pct = 95;
        1: pct = 60;
        default: pct = 15;
      endcase
      repeat (PhaseTicks) queue_tick(rand_tick(pct));
      settle();
    end

    // Receiver holds off while every tick closes a window: the block fills up
    cfg_write(AddrWindowTicks, 1);
    hold_requests++;
    repeat (40) queue_tick(rand_tick(100));
    settle();

    $display("windowed_min_max_mean_unit_test: %0d ticks, %0d summaries, %0d empty windows,",
             ticks_taken, summaries_seen, empty_windows);
    $display("windowed_min_max_mean_unit_test: %0d window length writes, one long receiver hold",
             length_writes);
    if (fault_count == 0) begin
      $display("windowed_min_max_mean_unit_test: clean");
    end else begin
      $display("windowed_min_max_mean_unit_test: errors");
    end
    $finish;
  end

endmodule
